// ===== rtl/ace_pkg.sv =====
`default_nettype none

package ace_pkg;

	// stream and config port widths
	localparam int unsigned IN_DATA_W  = 136;
	localparam int unsigned IN_USER_W  = 1;
	localparam int unsigned OUT_DATA_W = 96;
	localparam int unsigned OUT_USER_W = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_LEAK     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE      = 3'd4;

	// register reset values
	localparam logic [16:0] BLEND_WEIGHT_RST = 17'd58982;
	localparam logic [16:0] VEL_LEAK_RST     = 17'd65208;
	localparam logic [23:0] VEL_GAIN_RST     = 24'd65536;
	localparam logic [19:0] DEADBAND_RST     = 20'd2621;
	localparam logic [15:0] MAX_AGE_RST      = 16'd50;

	// fixed point constants
	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [19:0] GRAVITY_Q16 = 20'd642908;

	// item kinds
	localparam logic CMD_ACCEL    = 1'b0;
	localparam logic CMD_ESTIMATE = 1'b1;

	// sequencer states
	typedef enum logic [22:0] {
		ST_IDLE     = 23'h000001,
		ST_ACC_DB   = 23'h000002,
		ST_ACC_M1   = 23'h000004,
		ST_ACC_R1   = 23'h000008,
		ST_ACC_M2   = 23'h000010,
		ST_ACC_R2   = 23'h000020,
		ST_ACC_M3   = 23'h000040,
		ST_ACC_R3   = 23'h000080,
		ST_EST_M1   = 23'h000100,
		ST_EST_R1   = 23'h000200,
		ST_EST_M2   = 23'h000400,
		ST_EST_M3   = 23'h000800,
		ST_EST_R2   = 23'h001000,
		ST_EST_M4   = 23'h002000,
		ST_EST_M5   = 23'h004000,
		ST_EST_R3   = 23'h008000,
		ST_EST_R4   = 23'h010000,
		ST_EST_R5   = 23'h020000,
		ST_EST_DIFF = 23'h040000,
		ST_DIV_SET  = 23'h080000,
		ST_DIV_STEP = 23'h100000,
		ST_DIV_END  = 23'h200000,
		ST_DONE     = 23'h400000
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/altitude_complementary_estimator_core.sv =====
// accel item: ACC_DB, ACC_M1 to ACC_R3, then DONE; a new beat is taken only back in IDLE
// estimate item: EST_M1 through EST_DIFF, then DIV_SET and the steps of the restoring
// divider of the rate, which are skipped when step_time is zero or the rate saturates
// all products go through one shared 32x24 multiplier under the sequencer
// arst_n low clears the sequencer, the output valid flag, altitude, velocity,
// previous altitude and surface mode, and loads the register defaults
`default_nettype none

module altitude_complementary_estimator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// accel_z, range_distance, range_timestamp, current_tick, step_time, zero pad
	input  logic [ace_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// cmd
	input  logic [ace_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// altitude, vertical_rate, integrated_velocity
	output logic [ace_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// surface_mode, sample_fresh, rate_invalid
	output logic [ace_pkg::OUT_USER_W-1:0]    m_axis_tuser,
	input  logic                              cfg_wr_en,
	input  logic [ace_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ace_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ace_pkg::*;

	// saturate to signed 32 bits
	function automatic logic [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (v < -48'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	state_t state_q;
	logic [4:0] cnt_q;

	// configuration, weights stored already capped at one
	logic [16:0] blend_q;
	logic [16:0] leak_q;
	logic [23:0] gain_q;
	logic [19:0] deadband_q;
	logic [15:0] max_age_q;

	// kept estimator state
	logic [31:0] alt_q;
	logic [31:0] vel_q;
	logic [31:0] prev_q;
	logic        surface_q;

	// captured beat
	logic        cmd_q;
	logic [20:0] acc_q;
	logic [21:0] dist_q;
	logic [31:0] stamp_q;
	logic [31:0] now_q;
	logic [23:0] dt_q;

	// working registers
	logic [55:0]        prod_q;
	logic [55:0]        lo_q;
	logic [20:0]        dbm_q;
	logic               neg_q;
	logic [20:0]        tm_q;
	logic [39:0]        a1m_q;
	logic [39:0]        advm_q;
	logic               adv_neg_q;
	logic signed [48:0] term_q;
	logic signed [48:0] sum_q;
	logic signed [33:0] f_q;
	logic signed [32:0] diff_q;
	logic [23:0]        rem_q;
	logic [31:0]        div_q;
	logic               rate_neg_q;
	logic [31:0]        rate_q;
	logic               fresh_q;
	logic               invalid_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_alt_q;
	logic [31:0] out_rate_q;
	logic [31:0] out_vel_q;
	logic [2:0]  out_flags_q;

	logic        in_beat;
	logic        out_free;
	logic [31:0] mul_a;
	logic [23:0] mul_b;

	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_vel_q, out_rate_q, out_alt_q};
	assign m_axis_tuser  = out_flags_q;

	// magnitudes of the kept values
	logic [31:0] vel_mag;
	logic [31:0] alt_mag;
	assign vel_mag = vel_q[31] ? (~vel_q + 32'd1) : vel_q;
	assign alt_mag = alt_q[31] ? (~alt_q + 32'd1) : alt_q;

	// deadband on acceleration magnitude
	logic [20:0] acc_mag;
	logic [20:0] db_mag;
	assign acc_mag = acc_q[20] ? (~acc_q + 21'd1) : acc_q;
	assign db_mag  = (acc_mag < {1'b0, deadband_q}) ? 21'd0 : (acc_mag - {1'b0, deadband_q});

	// shared round-to-nearest of the product by 2^16 and 2^24
	logic [56:0] rnd16;
	logic [44:0] rnd24;
	assign rnd16 = {1'b0, prod_q} + 57'h0_8000;
	assign rnd24 = prod_q[44:0] + 45'h80_0000;

	// velocity plus scaled acceleration
	logic signed [33:0] dv_pos;
	logic signed [33:0] dv_s;
	logic signed [33:0] vel_sum;
	assign dv_pos  = $signed({9'b0, rnd16[40:16]});
	assign dv_s    = neg_q ? -dv_pos : dv_pos;
	assign vel_sum = $signed({{2{vel_q[31]}}, vel_q}) + dv_s;

	// leaked velocity
	logic signed [32:0] leak_pos;
	logic signed [32:0] leak_s;
	assign leak_pos = $signed({1'b0, rnd16[47:16]});
	assign leak_s   = vel_q[31] ? -leak_pos : leak_pos;

	// range sample age
	logic [31:0] age;
	logic        fresh_now;
	assign age       = now_q - stamp_q;
	assign fresh_now = (age <= {16'b0, max_age_q});

	// altitude advance, low and high partial products
	logic [63:0] adv_full;
	logic [63:0] adv_rnd;
	assign adv_full = {8'b0, lo_q} + {prod_q[31:0], 32'b0};
	assign adv_rnd  = adv_full + 64'h80_0000;

	// rounding of the blended sum
	logic [48:0] sum_mag;
	logic [48:0] sum_rnd;
	logic signed [33:0] f_pos;
	assign sum_mag = sum_q[48] ? 49'(-sum_q) : 49'(sum_q);
	assign sum_rnd = sum_mag + 49'h8000;
	assign f_pos   = $signed({1'b0, sum_rnd[48:16]});

	// new altitude with the advance applied
	logic signed [47:0] alt_base;
	logic signed [47:0] adv_ext;
	logic signed [47:0] alt_new;
	assign alt_base = fresh_q ? 48'(f_q) : 48'($signed(alt_q));
	assign adv_ext  = $signed({8'b0, advm_q});
	assign alt_new  = adv_neg_q ? (alt_base - adv_ext) : (alt_base + adv_ext);

	// divider setup
	logic [32:0] diff_mag;
	logic [24:0] div_hi;
	logic        div_ovf;
	assign diff_mag = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
	assign div_hi   = diff_mag[32:8];
	assign div_ovf  = (div_hi >= {1'b0, dt_q});

	// one restoring divider step
	logic [24:0] div_r;
	logic        div_ge;
	logic [24:0] div_sub;
	assign div_r   = {rem_q, div_q[31]};
	assign div_ge  = (div_r >= {1'b0, dt_q});
	assign div_sub = div_r - {1'b0, dt_q};

	// shared multiplier operand select
	always_comb begin
		mul_a = 32'd0;
		mul_b = 24'd0;
		unique case (state_q)
			ST_ACC_M1: begin
				mul_a = {11'b0, dbm_q};
				mul_b = dt_q;
			end
			ST_ACC_M2: begin
				mul_a = {11'b0, tm_q};
				mul_b = {4'b0, GRAVITY_Q16};
			end
			ST_ACC_M3: begin
				mul_a = vel_mag;
				mul_b = {7'b0, leak_q};
			end
			ST_EST_M1: begin
				mul_a = vel_mag;
				mul_b = gain_q;
			end
			ST_EST_M2: begin
				mul_a = a1m_q[31:0];
				mul_b = dt_q;
			end
			ST_EST_M3: begin
				mul_a = {24'b0, a1m_q[39:32]};
				mul_b = dt_q;
			end
			ST_EST_M4: begin
				mul_a = alt_mag;
				mul_b = {7'b0, blend_q};
			end
			ST_EST_M5: begin
				mul_a = {10'b0, dist_q};
				mul_b = {7'b0, ONE_Q16 - blend_q};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 24'd0;
			end
		endcase
	end

	// sequencer, kept state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
			alt_q       <= 32'd0;
			vel_q       <= 32'd0;
			prev_q      <= 32'd0;
			surface_q   <= 1'b0;
			blend_q     <= BLEND_WEIGHT_RST;
			leak_q      <= VEL_LEAK_RST;
			gain_q      <= VEL_GAIN_RST;
			deadband_q  <= DEADBAND_RST;
			max_age_q   <= MAX_AGE_RST;
		end else begin
			// register writes
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_BLEND_WEIGHT: blend_q <= (cfg_data[16:0] > ONE_Q16) ? ONE_Q16 : cfg_data[16:0];
					REG_VEL_LEAK:     leak_q  <= (cfg_data[16:0] > ONE_Q16) ? ONE_Q16 : cfg_data[16:0];
					REG_VEL_GAIN:     gain_q  <= cfg_data;
					REG_DEADBAND:     deadband_q <= cfg_data[19:0];
					REG_MAX_AGE:      max_age_q  <= cfg_data[15:0];
					default: ;
				endcase
			end

			// result beat taken, unless a new one is loaded below
			if (m_axis_tvalid && m_axis_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= (s_axis_tuser[0] == CMD_ESTIMATE) ? ST_EST_M1 : ST_ACC_DB;
					end
				end
				ST_ACC_DB: state_q <= ST_ACC_M1;
				ST_ACC_M1: state_q <= ST_ACC_R1;
				ST_ACC_R1: state_q <= ST_ACC_M2;
				ST_ACC_M2: state_q <= ST_ACC_R2;
				ST_ACC_R2: begin
					vel_q   <= sat32(48'(vel_sum));
					state_q <= ST_ACC_M3;
				end
				ST_ACC_M3: state_q <= ST_ACC_R3;
				ST_ACC_R3: begin
					vel_q   <= sat32(48'(leak_s));
					state_q <= ST_DONE;
				end
				ST_EST_M1: state_q <= ST_EST_R1;
				ST_EST_R1: begin
					surface_q <= surface_q | fresh_now;
					state_q   <= ST_EST_M2;
				end
				ST_EST_M2: state_q <= ST_EST_M3;
				ST_EST_M3: state_q <= ST_EST_R2;
				ST_EST_R2: begin
					priority if (fresh_q) begin
						state_q <= ST_EST_M4;
					end else if (!surface_q) begin
						state_q <= ST_EST_R5;
					end else begin
						state_q <= ST_EST_DIFF;
					end
				end
				ST_EST_M4: state_q <= ST_EST_M5;
				ST_EST_M5: state_q <= ST_EST_R3;
				ST_EST_R3: state_q <= ST_EST_R4;
				ST_EST_R4: state_q <= ST_EST_R5;
				ST_EST_R5: begin
					alt_q   <= sat32(alt_new);
					state_q <= ST_EST_DIFF;
				end
				ST_EST_DIFF: begin
					prev_q  <= alt_q;
					state_q <= ST_DIV_SET;
				end
				ST_DIV_SET: begin
					cnt_q <= 5'd0;
					if (dt_q == 24'd0 || div_ovf) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV_STEP;
					end
				end
				ST_DIV_STEP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_DIV_END;
					end
				end
				ST_DIV_END: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					cmd_q     <= s_axis_tuser[0];
					acc_q     <= s_axis_tdata[20:0];
					dist_q    <= s_axis_tdata[42:21];
					stamp_q   <= s_axis_tdata[74:43];
					now_q     <= s_axis_tdata[106:75];
					dt_q      <= s_axis_tdata[130:107];
					rate_q    <= 32'd0;
					fresh_q   <= 1'b0;
					invalid_q <= 1'b0;
				end
			end
			ST_ACC_DB: begin
				dbm_q <= db_mag;
				neg_q <= acc_q[20];
			end
			ST_ACC_R1: tm_q <= rnd24[44:24];
			ST_EST_R1: begin
				a1m_q     <= rnd16[55:16];
				adv_neg_q <= vel_q[31];
				fresh_q   <= fresh_now;
			end
			ST_EST_M3: lo_q <= prod_q;
			ST_EST_R2: advm_q <= adv_rnd[63:24];
			ST_EST_M5: begin
				term_q <= alt_q[31] ? -$signed({1'b0, prod_q[47:0]})
				                    : $signed({1'b0, prod_q[47:0]});
			end
			ST_EST_R3: sum_q <= term_q + $signed({1'b0, prod_q[47:0]});
			ST_EST_R4: f_q <= sum_q[48] ? -f_pos : f_pos;
			ST_EST_DIFF: begin
				diff_q <= $signed({alt_q[31], alt_q}) - $signed({prev_q[31], prev_q});
			end
			ST_DIV_SET: begin
				rate_neg_q <= diff_q[32];
				rem_q      <= div_hi[23:0];
				div_q      <= {diff_mag[7:0], 24'b0};
				priority if (dt_q == 24'd0) begin
					invalid_q <= 1'b1;
					rate_q    <= 32'd0;
				end else if (div_ovf) begin
					rate_q <= diff_q[32] ? 32'h8000_0000 : 32'h7fff_ffff;
				end
			end
			ST_DIV_STEP: begin
				rem_q <= div_ge ? div_sub[23:0] : div_r[23:0];
				div_q <= {div_q[30:0], div_ge};
			end
			ST_DIV_END: begin
				priority if (!rate_neg_q) begin
					rate_q <= div_q[31] ? 32'h7fff_ffff : div_q;
				end else if (div_q > 32'h8000_0000) begin
					rate_q <= 32'h8000_0000;
				end else begin
					rate_q <= ~div_q + 32'd1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_alt_q   <= alt_q;
					out_rate_q  <= (cmd_q == CMD_ESTIMATE) ? rate_q : 32'd0;
					out_vel_q   <= vel_q;
					out_flags_q <= {invalid_q, fresh_q, surface_q};
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
